// ===== rtl/core/l2vn_pkg.sv =====
// Shared widths, constants and types for the L2 vector normaliser.
// No dependencies; imported by the top level, the divider and the testbench.
`default_nettype none

package l2vn_pkg;

  localparam int unsigned VECTOR_LEN_DEF = 64;

  localparam int unsigned ELEM_W = 16;               // Q8.8 element
  localparam int unsigned MAG_W  = 16;               // magnitude of an element
  localparam int unsigned SQ_W   = 2 * MAG_W;        // one square
  localparam int unsigned SUM_W  = 37;               // sum of squares
  localparam int unsigned ROOT_W = (SUM_W + 1) / 2;  // floor square root
  localparam int unsigned Q_W    = 16;               // Q1.15 result

  localparam int unsigned DIV_BITS_PER_CYC = 4;
  localparam int unsigned DIV_CYCLES       = Q_W / DIV_BITS_PER_CYC;

  localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7FFF;
  localparam logic [Q_W-1:0] Q_NEG_MAG = 16'h8000;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] code;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/l2_vector_normalizer_core.sv =====
// L2 vector normaliser: top level. Buffers a vector, takes its norm and
// emits every element divided by it. Depends on l2vn_pkg, l2vn_ram, l2vn_div.
//
// Usage:
//   Input channel (in_valid / in_stall): one signed Q8.8 element per transfer,
//   in_end_of_vector marks the last one. An element that fills the buffer
//   (VECTOR_LEN entries) also closes the vector. While loading, one transfer
//   is taken every cycle.
//   Result channel (out_valid / out_stall): one Q1.15 result per stored
//   element, in arrival order; out_last_of_vector flags the final one and
//   out_zero_vector flags every result of a vector whose norm is zero
//   (values are then zero).
//   Sequence: after the closing transfer, a flush step folds in the last
//   square, the bit-serial square root runs (one result bit a cycle over
//   the 37-bit sum), then the first element is read, divided and loaded.
//   While emitting, the shared divider (4 bits a cycle) takes one element
//   at a time and holds it until its result is loaded into the output
//   register; the next element is read from the element buffer as that
//   result is loaded. in_stall is held high from the closing transfer until
//   the last result has been loaded into the output register.
//   A stalled receiver holds the output register; the divider result waits
//   until the register drains. Synchronous reset empties the vector and the
//   output register; buffer contents are left as they are.
`default_nettype none

module l2_vector_normalizer_core #(
  parameter int unsigned VECTOR_LEN = l2vn_pkg::VECTOR_LEN_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [l2vn_pkg::ELEM_W-1:0] in_element_value,
  input  wire logic                        in_end_of_vector,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [l2vn_pkg::Q_W-1:0]  out_normalized_value,
  output logic                             out_last_of_vector,
  output logic                             out_zero_vector
);

  import l2vn_pkg::*;

  localparam int unsigned AW     = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int unsigned CW     = $clog2(VECTOR_LEN + 1);
  localparam int unsigned SQ_TOP = 2 * ((SUM_W - 1) / 2);
  localparam int unsigned RT_W   = SUM_W + 1;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FLUSH = 3'd1;
  localparam logic [2:0] S_SQRT  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;

  logic [2:0]        state_r;
  logic [CW-1:0]     cnt_r, cnt_inc;
  logic [CW-1:0]     k_r, k_inc;
  logic              sq_vld_r;
  logic [SQ_W-1:0]   sq_r;
  logic [SUM_W-1:0]  sum_r;
  logic              out_vld_r;

  // Square root working registers
  logic [SUM_W-1:0]  v_r, v_nxt;
  logic [RT_W-1:0]   root_r, root_nxt;
  logic [SUM_W-1:0]  bit_r, bit_nxt;

  logic              in_acc, vec_end, last_k, put, zero_norm;
  logic [MAG_W-1:0]  in_mag, rd_mag;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [ELEM_W-1:0] rd_data;
  logic              div_start;
  div_sts_t          div_sts;

  // ---------------------------------------------------------------------
  // Input side: take transfers only while loading
  // ---------------------------------------------------------------------
  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign cnt_inc  = cnt_r + CW'(1);
  assign vec_end  = in_end_of_vector || (cnt_inc == CW'(VECTOR_LEN));
  assign in_mag   = in_element_value[ELEM_W-1] ? MAG_W'(~in_element_value + 1'b1)
                                               : MAG_W'(in_element_value);

  // ---------------------------------------------------------------------
  // Emission side
  // ---------------------------------------------------------------------
  assign k_inc     = k_r + CW'(1);
  assign last_k    = (k_inc == cnt_r);
  assign zero_norm = (root_r[ROOT_W-1:0] == '0);
  assign put       = (state_r == S_DIV) && div_sts.done && (!out_vld_r || !out_stall);
  assign div_start = (state_r == S_START);

  // Prefetch the next element in the cycle that loads a result
  assign rd_en   = (state_r == S_RD) || (put && !last_k);
  assign rd_addr = put ? k_inc[AW-1:0] : k_r[AW-1:0];
  assign rd_mag  = rd_data[ELEM_W-1] ? MAG_W'(~rd_data + 1'b1) : MAG_W'(rd_data);

  // ---------------------------------------------------------------------
  // Bit-serial floor square root, one result bit a cycle
  // ---------------------------------------------------------------------
  always_comb begin
    logic [RT_W-1:0] trial;
    trial = root_r + RT_W'(bit_r);
    if ({1'b0, v_r} >= trial) begin
      v_nxt    = v_r - trial[SUM_W-1:0];
      root_nxt = (root_r >> 1) + RT_W'(bit_r);
    end else begin
      v_nxt    = v_r;
      root_nxt = root_r >> 1;
    end
    bit_nxt = bit_r >> 2;
  end

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      k_r       <= '0;
      sq_vld_r  <= 1'b0;
      sum_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      sq_vld_r  <= in_acc;
      // Load a new result or hold the waiting one while the receiver stalls
      out_vld_r <= put || (out_vld_r && out_stall);
      case (state_r)
        S_LOAD: begin
          // Accumulate the square registered on the previous transfer
          if (sq_vld_r) begin
            sum_r <= sum_r + SUM_W'(sq_r);
          end
          if (in_acc) begin
            cnt_r <= cnt_inc;
            if (vec_end) begin
              state_r <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          sum_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (bit_r == '0) begin
            k_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (put) begin
            if (last_k) begin
              cnt_r   <= '0;
              k_r     <= '0;
              state_r <= S_LOAD;
            end else begin
              k_r     <= k_inc;
              state_r <= S_START;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq_r <= in_mag * in_mag;
    end
    if (state_r == S_FLUSH) begin
      v_r    <= sum_r + SUM_W'(sq_r);
      root_r <= '0;
      bit_r  <= SUM_W'(1) << SQ_TOP;
    end else if ((state_r == S_SQRT) && (bit_r != '0)) begin
      v_r    <= v_nxt;
      root_r <= root_nxt;
      bit_r  <= bit_nxt;
    end
    if (put) begin
      out_normalized_value <= zero_norm ? '0 : div_sts.code;
      out_last_of_vector   <= last_k;
      out_zero_vector      <= zero_norm;
    end
  end

  assign out_valid = out_vld_r;

  // ---------------------------------------------------------------------
  // Element buffer and shared divider
  // ---------------------------------------------------------------------
  l2vn_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (VECTOR_LEN)
  ) u_buf (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_element_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  l2vn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (rd_mag),
    .neg     (rd_data[ELEM_W-1]),
    .divisor (root_r[ROOT_W-1:0]),
    .sts     (div_sts)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(VECTOR_LEN))
    else $error("element count beyond buffer depth");

  a_k_in_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_START || state_r == S_DIV) |-> (k_r < cnt_r))
    else $error("emission index outside the stored vector");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_vector) |-> (out_normalized_value == '0))
    else $error("zero-norm result carries a non-zero value");

endmodule

`default_nettype wire

// ===== rtl/core/l2vn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module l2vn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/l2vn_div.sv =====
// Multi-cycle restoring divider: (mag << 15) / divisor, four quotient bits a cycle,
// with signed Q1.15 saturation of the result. Depends on l2vn_pkg.
`default_nettype none

module l2vn_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [l2vn_pkg::MAG_W-1:0]  mag,
  input  wire logic                      neg,
  input  wire logic [l2vn_pkg::ROOT_W-1:0] divisor,
  output l2vn_pkg::div_sts_t             sts
);

  import l2vn_pkg::*;

  localparam int unsigned CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  logic [ROOT_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]    dvd_r, dvd_nxt;
  logic [Q_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r, neg_r;
  logic [Q_W-1:0]    q_sat;

  // Four dependent restoring steps per cycle on narrow values
  always_comb begin
    logic [ROOT_W:0] trial;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    for (int i = 0; i < DIV_BITS_PER_CYC; i++) begin
      trial = {rem_nxt, dvd_nxt[Q_W-1]};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = ROOT_W'(trial - {1'b0, divisor});
        quo_nxt = {quo_nxt[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ROOT_W-1:0];
        quo_nxt = {quo_nxt[Q_W-2:0], 1'b0};
      end
      dvd_nxt = {dvd_nxt[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_CYCLES - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Dividend is mag followed by fifteen zeros; top fifteen bits seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= ROOT_W'(mag[MAG_W-1:1]);
      dvd_r <= {mag[0], {(Q_W-1){1'b0}}};
      quo_r <= '0;
      neg_r <= neg;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_comb begin
    if (neg_r) begin
      q_sat = (quo_r > Q_NEG_MAG) ? Q_NEG_MAG : quo_r;
      q_sat = ~q_sat + Q_W'(1);
    end else begin
      q_sat = (quo_r > Q_POS_MAX) ? Q_POS_MAX : quo_r;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.code = q_sat;

endmodule

`default_nettype wire

// ===== verif/tb_l2_vector_normalizer_core.sv =====
// Self-checking testbench for l2_vector_normalizer_core: directed and random vectors,
// results compared against an in-bench model of the L2 normalisation or typed answers.
// Depends on l2vn_pkg and the l2_vector_normalizer_core RTL.
module tb_l2_vector_normalizer_core;
  import l2vn_pkg::*;

  localparam int VEC_LEN       = VECTOR_LEN_DEF;
  localparam int RANDOM_ITEMS  = 395;
  // Longest quiet stretch a correct run can show: a long sender gap, the root
  // pass and a long receiver stall, taken many times over.
  localparam int IDLE_LIMIT    = 3000;
  // Cycles to wait after the last result: root pass plus one divide, with margin.
  localparam int SETTLE_CYCLES = 64;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [Q_W-1:0]    qcode_t;
  typedef logic [ROOT_W-1:0]        root_t;
  typedef longint unsigned          u64_t;

  typedef struct packed {
    qcode_t value;
    logic   last;
    logic   zero;
  } unit_elem_t;

  // One row of the directed table; single-element vectors carry a typed answer.
  typedef struct {
    elem_t  value;
    logic   eov;
    logic   typed;
    qcode_t want_value;
    logic   want_zero;
  } probe_row_t;

  logic   clk;
  logic   rst_n            = 1'b0;
  logic   in_valid         = 1'b0;
  elem_t  in_element_value = '0;
  logic   in_end_of_vector = 1'b0;
  logic   out_stall        = 1'b0;
  logic   in_stall;
  logic   out_valid;
  qcode_t out_normalized_value;
  logic   out_last_of_vector;
  logic   out_zero_vector;

  // In-bench copy of the vector being gathered and the results still owed.
  elem_t        gathered [VEC_LEN];
  logic [SUM_W-1:0] energy_sum  = '0;
  int           gathered_count = 0;
  unit_elem_t   owed_results [$];

  int         fail_count  = 0;
  int         idle_cycles = 0;
  int         stall_run   = 0;
  bit         steady      = 1'b0;
  unit_elem_t head;

  probe_row_t probe_rows [25] = '{
    // lone elements: the norm equals the magnitude, so the answer is +/-1.0 (zero for a zero element)
    '{16'sd0,     1'b1, 1'b1, 16'sd0,     1'b1},
    '{16'sd32767, 1'b1, 1'b1, 16'sd32767, 1'b0},
    '{16'sh8000,  1'b1, 1'b1, 16'sh8000,  1'b0},
    '{16'sd1,     1'b1, 1'b1, 16'sd32767, 1'b0},
    '{-16'sd1,    1'b1, 1'b1, 16'sh8000,  1'b0},
    '{16'sd256,   1'b1, 1'b1, 16'sd32767, 1'b0},
    // zero vector over several elements
    '{16'sd0,     1'b0, 1'b0, 16'sd0, 1'b0},
    '{16'sd0,     1'b0, 1'b0, 16'sd0, 1'b0},
    '{16'sd0,     1'b1, 1'b0, 16'sd0, 1'b0},
    // 3-4-5 triangle in Q8.8
    '{16'sd768,   1'b0, 1'b0, 16'sd0, 1'b0},
    '{16'sd1024,  1'b1, 1'b0, 16'sd0, 1'b0},
    // floored root below the true norm: both results clamp
    '{16'sd1,     1'b0, 1'b0, 16'sd0, 1'b0},
    '{16'sd1,     1'b1, 1'b0, 16'sd0, 1'b0},
    '{-16'sd1,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{-16'sd1,    1'b1, 1'b0, 16'sd0, 1'b0},
    // opposite extremes
    '{16'sd32767, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{16'sh8000,  1'b1, 1'b0, 16'sd0, 1'b0},
    // zero next to a non-zero element
    '{16'sd0,     1'b0, 1'b0, 16'sd0, 1'b0},
    '{-16'sd5,    1'b1, 1'b0, 16'sd0, 1'b0},
    // largest squares, summed
    '{16'sh8000,  1'b0, 1'b0, 16'sd0, 1'b0},
    '{16'sh8000,  1'b0, 1'b0, 16'sd0, 1'b0},
    '{16'sh8000,  1'b1, 1'b0, 16'sd0, 1'b0},
    // mixed signs and sizes
    '{16'sd12345, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{-16'sd2,    1'b0, 1'b0, 16'sd0, 1'b0},
    '{16'sd7,     1'b1, 1'b0, 16'sd0, 1'b0}
  };

  l2_vector_normalizer_core #(
    .VECTOR_LEN (VEC_LEN)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_element_value     (in_element_value),
    .in_end_of_vector     (in_end_of_vector),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_normalized_value (out_normalized_value),
    .out_last_of_vector   (out_last_of_vector),
    .out_zero_vector      (out_zero_vector)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Floor square root by setting result bits from the top down.
  function automatic root_t root_floor(logic [SUM_W-1:0] sum);
    root_t root;
    root_t trial;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (root_t'(1) << b);
      if ((2*ROOT_W)'(trial) * (2*ROOT_W)'(trial) <= (2*ROOT_W)'(sum))
        root = trial;
    end
    return root;
  endfunction

  // Element over norm in Q1.15, truncated toward zero, +1.0 clamped.
  function automatic qcode_t unit_scale(elem_t x, root_t norm);
    longint xi;
    u64_t   quo;
    xi  = x;
    quo = (u64_t'(xi < 0 ? -xi : xi) << 15) / u64_t'(norm);
    if (xi < 0) begin
      if (quo > 64'd32768)
        quo = 64'd32768;
      return qcode_t'(64'd0 - quo);
    end
    if (quo > 64'd32767)
      quo = 64'd32767;
    return qcode_t'(quo);
  endfunction

  // Append one result to the tail of the owed list.
  task automatic owe_result(unit_elem_t r);
    owed_results.insert(owed_results.size(), r);
  endtask

  // Absorb one accepted element; close the vector on its end mark or a full buffer.
  task automatic absorb_element(elem_t x, logic eov);
    longint     xi;
    root_t      norm;
    unit_elem_t r;
    xi = x;
    gathered[gathered_count] = x;
    energy_sum = energy_sum + SUM_W'(xi * xi);
    gathered_count++;
    if (eov || gathered_count == VEC_LEN) begin
      norm = root_floor(energy_sum);
      for (int k = 0; k < gathered_count; k++) begin
        r.zero  = (norm == '0);
        r.value = r.zero ? qcode_t'(0) : unit_scale(gathered[k], norm);
        r.last  = (k == gathered_count - 1);
        owe_result(r);
      end
      energy_sum     = '0;
      gathered_count = 0;
    end
  endtask

  // Mostly short idles, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14)
      return $urandom_range(1, 3);
    if (pick < 19)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic elem_t draw_element(int style);
    case (style)
      0: return elem_t'($urandom);
      1: return elem_t'(int'($urandom_range(0, 600)) - 300);
      2: return '0;
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'sd32767;
          1: return 16'sh8000;
          2: return 16'sd0;
          3: return 16'sd1;
          4: return -16'sd1;
          default: return elem_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Offer one element and hold it until the transfer completes.
  task automatic offer_element(elem_t x, logic eov);
    int gap;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= x;
    in_end_of_vector <= eov;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold off until every owed result has been taken.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  // Receiver: stall in random runs, except during steady stretches.
  always @(posedge clk) begin
    if (stall_run == 0 && !steady && $urandom_range(0, 3) == 0)
      stall_run = idle_len();
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run = stall_run - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every result transfer with the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $error("result with none owed: normalized_value %0d last %0b zero %0b",
               out_normalized_value, out_last_of_vector, out_zero_vector);
        fail_count++;
      end else begin
        head = owed_results.pop_front();
        if (out_normalized_value !== head.value) begin
          $error("normalized_value: expected %0d, got %0d", head.value, out_normalized_value);
          fail_count++;
        end
        if (out_last_of_vector !== head.last) begin
          $error("last_of_vector: expected %0b, got %0b", head.last, out_last_of_vector);
          fail_count++;
        end
        if (out_zero_vector !== head.zero) begin
          $error("zero_vector: expected %0b, got %0b", head.zero, out_zero_vector);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int         sent;
    int         vec_idx;
    int         len;
    int         style;
    int         pick;
    logic       eov_last;
    logic       eov;
    elem_t      x;
    unit_elem_t typed;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: lone elements are checked against typed answers.
    for (int i = 0; i < $size(probe_rows); i++) begin
      offer_element(probe_rows[i].value, probe_rows[i].eov);
      if (probe_rows[i].typed) begin
        typed.value = probe_rows[i].want_value;
        typed.last  = 1'b1;
        typed.zero  = probe_rows[i].want_zero;
        owe_result(typed);
      end else begin
        absorb_element(probe_rows[i].value, probe_rows[i].eov);
      end
    end
    hold_until_drained();

    // Random vectors: mostly short, a few filling the buffer.
    sent    = 0;
    vec_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 5) == 0);
      pick   = $urandom_range(0, 9);
      style  = (pick < 4) ? 0 : (pick < 7) ? 1 : (pick == 7) ? 2 : 3;
      if (vec_idx == 0 || vec_idx == 5 || $urandom_range(0, 39) == 0)
        len = VEC_LEN;
      else if ($urandom_range(0, 4) == 0)
        len = $urandom_range(9, VEC_LEN - 1);
      else
        len = $urandom_range(1, 8);
      // A full buffer closes the vector with or without the end mark.
      if (len < VEC_LEN)
        eov_last = 1'b1;
      else if (vec_idx == 0)
        eov_last = 1'b0;
      else if (vec_idx == 5)
        eov_last = 1'b1;
      else
        eov_last = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        x   = draw_element(style);
        eov = (i == len - 1) ? eov_last : 1'b0;
        offer_element(x, eov);
        absorb_element(x, eov);
      end
      sent += len;
      vec_idx++;
      if (vec_idx == 3 || $urandom_range(0, 7) == 0)
        hold_until_drained();
    end

    in_valid <= 1'b0;
    steady   = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== l2_vector_normalizer_core.f =====
rtl/core/l2vn_pkg.sv
rtl/core/l2vn_ram.sv
rtl/core/l2vn_div.sv
rtl/core/l2_vector_normalizer_core.sv
verif/tb_l2_vector_normalizer_core.sv
